/* rtl/cliff_hysteresis_event_unit_top_macros.svh */
// ----------------------------------------------------------------------------
// Cliff hysteresis event unit - assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef CLIFF_HYSTERESIS_EVENT_UNIT_TOP_MACROS_SVH
`define CLIFF_HYSTERESIS_EVENT_UNIT_TOP_MACROS_SVH

// Same-cycle implication, off while in reset
`define CHEV_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("chev check failed: lbl");

// Next-cycle implication, off while in reset
`define CHEV_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("chev check failed: lbl");

`endif

/* rtl/chev_pkg.sv */
// ----------------------------------------------------------------------------
// Cliff hysteresis event unit - package
// Widths, reset values, register indexes and stream layout.
// ----------------------------------------------------------------------------
package chev_pkg;

    localparam int NUM_SENSORS    = 4;
    localparam int SAMPLE_BITS    = 16;
    localparam int NUM_CFG_THRESH = 4;

    localparam int THRESH_W   = 16;
    localparam int HYST_W     = 12;
    localparam int DELAY_W    = 16;
    localparam int TIME_W     = 32;
    localparam int FLAG_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(400);
    localparam logic [HYST_W-1:0]   HYST_RESET   = HYST_W'(50);
    localparam logic [DELAY_W-1:0]  DELAY_RESET  = DELAY_W'(500);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_ENABLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_ON_CLIFF = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_0   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS    = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] CFG_EVENT_DELAY   = CFG_IDX_W'(7);

    // Request layout, lowest bit first
    localparam int S_RAW_LSB      = 0;
    localparam int S_DRIVING_BIT  = NUM_SENSORS * SAMPLE_BITS;
    localparam int S_STOPPING_BIT = S_DRIVING_BIT + 1;
    localparam int S_LIFTED_BIT   = S_DRIVING_BIT + 2;
    localparam int S_NOW_LSB      = S_DRIVING_BIT + 3;
    localparam int S_USED_W       = S_NOW_LSB + TIME_W;
    localparam int S_TDATA_W      = ((S_USED_W + 7) / 8) * 8;

    // Result layout, lowest bit first
    localparam int M_FLAGS_LSB     = 0;
    localparam int M_STOP_BIT      = FLAG_W;
    localparam int M_NOTICE_BIT    = FLAG_W + 1;
    localparam int M_CLIFF_BIT     = FLAG_W + 2;
    localparam int M_EV_FLAGS_LSB  = FLAG_W + 3;
    localparam int M_EV_TIME_LSB   = M_EV_FLAGS_LSB + FLAG_W;
    localparam int M_EV_STOP_BIT   = M_EV_TIME_LSB + TIME_W;
    localparam int M_UNCLIFF_BIT   = M_EV_STOP_BIT + 1;
    localparam int M_USED_W        = M_UNCLIFF_BIT + 1;
    localparam int M_TDATA_W       = ((M_USED_W + 7) / 8) * 8;

endpackage

/* rtl/cliff_hysteresis_event_unit_top.sv */
// ----------------------------------------------------------------------------
// Cliff hysteresis event unit
// Per-sensor cliff flags with hysteresis, stop requests and delayed events.
// ----------------------------------------------------------------------------
// Usage:
//   s_tvalid/s_tready/s_tdata carry one sensor tick per request: four raw
//   readings, driving, already-stopping and picked-up flags and a ms time.
//   m_tvalid/m_tready/m_tdata return one result per tick: the cliff flags,
//   stop or potential-cliff request and any cliff/uncliff event released.
//   cfg_we/cfg_index/cfg_data write the eight setup registers; write only
//   while no request is in flight.
// Path: a request enters the input register at the accepting edge, and its
//   result enters the result register, which drives m_tvalid. Throughput:
//   one request per cycle while m_tready is high, set by the input-to-result step.
// Reset: all detector state clears, registers return to their defaults
//   (thresholds 400, hysteresis 50, delay 500 ms, detect and stop enabled).
// Stall: while m_tready is low the result holds; one more request is taken
//   into the input register, then s_tready drops until the result leaves.
// ----------------------------------------------------------------------------
module cliff_hysteresis_event_unit_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [chev_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [chev_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // raw_sensor_0..3, is_driving, already_stopping, picked_up, now_ms, zero pad
    input  logic [chev_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // cliff_flags, stop_motors, potential_cliff, cliff_event_sent, event_flags,
    // event_time, event_did_stop, uncliff_event_sent, zero pad
    output logic [chev_pkg::M_TDATA_W-1:0]      m_tdata
);
    import chev_pkg::*;

    // Setup registers
    logic                        detect_enable_reg;
    logic                        stop_on_cliff_reg;
    logic [THRESH_W-1:0]         threshold_reg [NUM_SENSORS];
    logic [HYST_W-1:0]           hysteresis_reg;
    logic [DELAY_W-1:0]          event_delay_reg;

    // Input and result stages
    logic                        in_valid_reg;
    logic [S_TDATA_W-1:0]        in_data_reg;
    logic                        out_valid_reg;
    logic [M_TDATA_W-1:0]        out_data_reg;
    logic [M_TDATA_W-1:0]        out_data_next;
    logic                        advance;

    // Detector state
    logic [SAMPLE_BITS-1:0]      held_reg [NUM_SENSORS];
    logic [SAMPLE_BITS-1:0]      held_next [NUM_SENSORS];
    logic [NUM_SENSORS-1:0]      flags_reg;
    logic [NUM_SENSORS-1:0]      flags_next;
    logic                        was_any_reg;
    logic                        was_any_next;
    logic                        was_lifted_reg;
    logic                        pc_valid_reg;
    logic                        pc_valid_next;
    logic [TIME_W-1:0]           pc_due_reg;
    logic [TIME_W-1:0]           pc_due_next;
    logic                        pu_valid_reg;
    logic                        pu_valid_next;
    logic [TIME_W-1:0]           pu_due_reg;
    logic [TIME_W-1:0]           pu_due_next;
    logic [TIME_W-1:0]           msg_time_reg;
    logic [TIME_W-1:0]           msg_time_next;
    logic [NUM_SENSORS-1:0]      msg_flags_reg;
    logic [NUM_SENSORS-1:0]      msg_flags_next;
    logic                        msg_stop_reg;
    logic                        msg_stop_next;

    // Fields of the held request
    logic                        driving;
    logic                        stopping;
    logic                        lifted;
    logic [TIME_W-1:0]           now;

    assign driving  = in_data_reg[S_DRIVING_BIT];
    assign stopping = in_data_reg[S_STOPPING_BIT];
    assign lifted   = in_data_reg[S_LIFTED_BIT];
    assign now      = in_data_reg[S_NOW_LSB +: TIME_W];

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Setup register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detect_enable_reg <= 1'b1;
            stop_on_cliff_reg <= 1'b1;
            hysteresis_reg    <= HYST_RESET;
            event_delay_reg   <= DELAY_RESET;
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                threshold_reg[i] <= THRESH_RESET;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DETECT_ENABLE: detect_enable_reg <= cfg_data[0];
                CFG_STOP_ON_CLIFF: stop_on_cliff_reg <= cfg_data[0];
                CFG_HYSTERESIS:    hysteresis_reg    <= cfg_data[HYST_W-1:0];
                CFG_EVENT_DELAY:   event_delay_reg   <= cfg_data[DELAY_W-1:0];
                default:           ;
            endcase
            // every sensor has a writable threshold, at CFG_THRESHOLD_0 plus its number
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                if (i < NUM_CFG_THRESH && cfg_index == CFG_IDX_W'(CFG_THRESHOLD_0 + i))
                begin
                    threshold_reg[i] <= cfg_data[THRESH_W-1:0];
                end
            end
        end
    end

    // Per-tick detector logic
    always_comb
    begin
        logic [SAMPLE_BITS-1:0] raw;
        logic [THRESH_W:0]      hi;
        logic                   any;
        logic                   stop_out;
        logic                   notice_out;
        logic                   cliff_sent;
        logic                   uncliff_sent;
        logic [NUM_SENSORS-1:0] ev_flags;
        logic [TIME_W-1:0]      ev_time;
        logic                   ev_stop;

        stop_out       = 1'b0;
        notice_out     = 1'b0;
        cliff_sent     = 1'b0;
        uncliff_sent   = 1'b0;
        ev_flags       = '0;
        ev_time        = '0;
        ev_stop        = 1'b0;
        flags_next     = flags_reg;
        was_any_next   = was_any_reg;
        pc_valid_next  = pc_valid_reg;
        pc_due_next    = pc_due_reg;
        pu_valid_next  = pu_valid_reg;
        pu_due_next    = pu_due_reg;
        msg_time_next  = msg_time_reg;
        msg_flags_next = msg_flags_reg;
        msg_stop_next  = msg_stop_reg;

        // Hold the last good reading, then apply the hysteresis band
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            raw          = in_data_reg[S_RAW_LSB + i*SAMPLE_BITS +: SAMPLE_BITS];
            held_next[i] = (raw != '0) ? raw : held_reg[i];
            hi           = {1'b0, threshold_reg[i]} + (THRESH_W+1)'(hysteresis_reg);
            if (!flags_reg[i])
            begin
                if ((THRESH_W)'(held_next[i]) < threshold_reg[i])
                begin
                    flags_next[i] = 1'b1;
                end
            end
            else if ((THRESH_W+1)'(held_next[i]) > hi)
            begin
                flags_next[i] = 1'b0;
            end
        end
        any = |flags_next;

        priority if (detect_enable_reg && any && !lifted && driving && !stopping
                     && !was_any_reg)
        begin
            stop_out   = stop_on_cliff_reg;
            notice_out = !stop_on_cliff_reg;
            if (!pc_valid_reg)
            begin
                pc_valid_next  = 1'b1;
                pc_due_next    = now + TIME_W'(event_delay_reg);
                msg_time_next  = now;
                msg_flags_next = flags_next;
                msg_stop_next  = stop_on_cliff_reg;
            end
            was_any_next = 1'b1;
        end
        else if (!any && was_any_reg)
        begin
            pu_valid_next = 1'b1;
            pu_due_next   = pc_valid_reg ? pc_due_reg : now;
            was_any_next  = 1'b0;
        end
        else
        begin
        end

        // Drop a queued cliff event on pickup
        if (lifted && !was_lifted_reg)
        begin
            pc_valid_next = 1'b0;
        end

        if (pc_valid_next)
        begin
            msg_flags_next = msg_flags_next | flags_next;
            if (now >= pc_due_next)
            begin
                cliff_sent    = 1'b1;
                ev_flags      = msg_flags_next;
                ev_time       = msg_time_next;
                ev_stop       = msg_stop_next;
                pc_valid_next = 1'b0;
            end
        end

        if (pu_valid_next && now >= pu_due_next)
        begin
            msg_flags_next = '0;
            uncliff_sent   = 1'b1;
            ev_time        = msg_time_next;
            ev_stop        = msg_stop_next;
            pu_valid_next  = 1'b0;
        end

        out_data_next = '0;
        out_data_next[M_FLAGS_LSB +: FLAG_W]    = FLAG_W'(flags_next);
        out_data_next[M_STOP_BIT]               = stop_out;
        out_data_next[M_NOTICE_BIT]             = notice_out;
        out_data_next[M_CLIFF_BIT]              = cliff_sent;
        out_data_next[M_EV_FLAGS_LSB +: FLAG_W] = FLAG_W'(ev_flags);
        out_data_next[M_EV_TIME_LSB +: TIME_W]  = ev_time;
        out_data_next[M_EV_STOP_BIT]            = ev_stop;
        out_data_next[M_UNCLIFF_BIT]            = uncliff_sent;
    end

    // Stage control and detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            flags_reg      <= '0;
            was_any_reg    <= 1'b0;
            was_lifted_reg <= 1'b0;
            pc_valid_reg   <= 1'b0;
            pc_due_reg     <= '0;
            pu_valid_reg   <= 1'b0;
            pu_due_reg     <= '0;
            msg_time_reg   <= '0;
            msg_flags_reg  <= '0;
            msg_stop_reg   <= 1'b0;
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                held_reg[i] <= '0;
            end
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                flags_reg      <= flags_next;
                was_any_reg    <= was_any_next;
                was_lifted_reg <= lifted;
                pc_valid_reg   <= pc_valid_next;
                pc_due_reg     <= pc_due_next;
                pu_valid_reg   <= pu_valid_next;
                pu_due_reg     <= pu_due_next;
                msg_time_reg   <= msg_time_next;
                msg_flags_reg  <= msg_flags_next;
                msg_stop_reg   <= msg_stop_next;
                for (int i = 0; i < NUM_SENSORS; i++)
                begin
                    held_reg[i] <= held_next[i];
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

/* rtl/chev_checker.sv */
// ----------------------------------------------------------------------------
// Cliff hysteresis event unit - port checker
// Result consistency and output hold seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "cliff_hysteresis_event_unit_top_macros.svh"

module chev_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // cliff_flags, stop_motors, potential_cliff, cliff_event_sent, event_flags,
    // event_time, event_did_stop, uncliff_event_sent, zero pad
    input  logic [chev_pkg::M_TDATA_W-1:0]      m_tdata
);
    import chev_pkg::*;

    `CHEV_ASSERT_IMPL(a_stop_xor_notice, clk, rst_n,
        m_tvalid, !(m_tdata[M_STOP_BIT] && m_tdata[M_NOTICE_BIT]))

    `CHEV_ASSERT_IMPL(a_request_has_flags, clk, rst_n,
        m_tvalid && (m_tdata[M_STOP_BIT] || m_tdata[M_NOTICE_BIT]),
        m_tdata[M_FLAGS_LSB +: FLAG_W] != '0)

    `CHEV_ASSERT_IMPL(a_no_event_no_flags, clk, rst_n,
        m_tvalid && !m_tdata[M_CLIFF_BIT], m_tdata[M_EV_FLAGS_LSB +: FLAG_W] == '0)

    `CHEV_ASSERT_NEXT(a_result_holds, clk, rst_n,
        m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind cliff_hysteresis_event_unit_top chev_checker u_chev_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
